[rtl/xtt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xtt_pkg
// Shared types and constants for the XML tag/text tokenizer.
// ----------------------------------------------------------------------------
package xtt_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_TEXT  = 6'b000010,
        MODE_LT    = 6'b000100,
        MODE_OPEN  = 6'b001000,
        MODE_CLOSE = 6'b010000,
        MODE_SKIP  = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        logic [1:0] token_kind;
        logic       has_char;
        logic [7:0] char_out;
        logic       token_end;
        logic       error_flag;
    } t_result;

endpackage : xtt_pkg
`default_nettype wire

[rtl/xml_tag_text_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xml_tag_text_tokenizer
// Splits a byte stream into text, open-tag and close-tag tokens.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     i_in_valid / o_in_ready    i_byte_in, i_end_of_input
//  output    o_out_valid / i_out_ready  o_token_kind, o_has_char, o_char_out,
//                                       o_token_end, o_error_flag
//
//  One byte per cycle sustained unless a stalled output holds the flow. A byte
//  is held in the input register, is classified by the scan-mode machine, and
//  its result (if any) is loaded into the output register.
//  Bytes that yield no result still advance the mode and are dropped.
//  A stalled output backs up only when a byte needs the occupied result slot.
//  Synchronous active-low reset returns the mode to between tokens.
// ----------------------------------------------------------------------------
module xml_tag_text_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_token_kind,
    output logic            o_has_char,
    output logic [7:0]      o_char_out,
    output logic            o_token_end,
    output logic            o_error_flag
);
    import xtt_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    emit;
    t_result scan_result;
    t_result out_result;
    logic    slot_free;
    logic    advance;
    logic    load;

    assign advance = item_valid && (!emit || slot_free);
    assign load    = advance && emit;

    xtt_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_byte_in      (i_byte_in),
        .i_end_of_input (i_end_of_input),
        .i_advance      (advance),
        .o_in_ready     (o_in_ready),
        .o_item_valid   (item_valid),
        .o_item         (item)
    );

    xtt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_step   (advance),
        .o_emit   (emit),
        .o_result (scan_result)
    );

    xtt_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_result    (scan_result),
        .i_out_ready (i_out_ready),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_token_kind = out_result.token_kind;
    assign o_has_char   = out_result.has_char;
    assign o_char_out   = out_result.char_out;
    assign o_token_end  = out_result.token_end;
    assign o_error_flag = out_result.error_flag;

endmodule : xml_tag_text_tokenizer
`default_nettype wire

[rtl/xtt_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xtt_in_stage
// Input register: captures one byte transaction and holds it until the
// scanner consumes it.
// ----------------------------------------------------------------------------
module xtt_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_byte_in,
    input  wire logic          i_end_of_input,
    input  wire logic          i_advance,
    output logic               o_in_ready,
    output logic               o_item_valid,
    output xtt_pkg::t_item     o_item
);
    import xtt_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_in_ready   = !r_valid || i_advance;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.byte_in      <= i_byte_in;
            r_item.end_of_input <= i_end_of_input;
        end
    end

endmodule : xtt_in_stage
`default_nettype wire

[rtl/xtt_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xtt_scan
// Scan-mode machine: classifies the held byte against the current mode and
// produces at most one token result per byte.
// ----------------------------------------------------------------------------
module xtt_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xtt_pkg::t_item i_item,
    input  wire logic          i_step,
    output logic               o_emit,
    output xtt_pkg::t_result   o_result
);
    import xtt_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [7:0] b;
    logic       is_lt;
    logic       is_gt;
    logic       is_slash;
    logic       is_space;

    assign b        = i_item.byte_in;
    assign is_lt    = (b == CH_LT);
    assign is_gt    = (b == CH_GT);
    assign is_slash = (b == CH_SLASH);
    assign is_space = (b == CH_SPACE);

    always_comb begin
        n_mode              = r_mode;
        o_emit              = 1'b0;
        o_result.token_kind = KIND_TEXT;
        o_result.has_char   = 1'b0;
        o_result.char_out   = 8'h00;
        o_result.token_end  = 1'b0;
        o_result.error_flag = 1'b0;

        if (i_item.end_of_input) begin
            // finish the stream; flag an end inside any tag
            n_mode              = MODE_IDLE;
            o_emit              = 1'b1;
            o_result.token_kind = KIND_DONE;
            o_result.error_flag = (r_mode == MODE_LT) || (r_mode == MODE_OPEN) ||
                                  (r_mode == MODE_CLOSE) || (r_mode == MODE_SKIP);
        end else begin
            unique case (r_mode)
                MODE_TEXT: begin
                    o_emit              = 1'b1;
                    o_result.token_kind = KIND_TEXT;
                    if (is_lt) begin
                        n_mode             = MODE_LT;
                        o_result.token_end = 1'b1;
                    end else begin
                        o_result.has_char = 1'b1;
                        o_result.char_out = b;
                    end
                end
                MODE_LT: begin
                    o_result.token_kind = KIND_OPEN;
                    if (is_slash) begin
                        n_mode = MODE_CLOSE;
                    end else if (is_gt || is_space) begin
                        n_mode             = is_gt ? MODE_IDLE : MODE_SKIP;
                        o_emit             = 1'b1;
                        o_result.token_end = 1'b1;
                    end else begin
                        n_mode            = MODE_OPEN;
                        o_emit            = 1'b1;
                        o_result.has_char = 1'b1;
                        o_result.char_out = b;
                    end
                end
                MODE_OPEN: begin
                    o_emit              = 1'b1;
                    o_result.token_kind = KIND_OPEN;
                    if (is_gt || is_space) begin
                        n_mode             = is_gt ? MODE_IDLE : MODE_SKIP;
                        o_result.token_end = 1'b1;
                    end else begin
                        o_result.has_char = 1'b1;
                        o_result.char_out = b;
                    end
                end
                MODE_CLOSE: begin
                    o_emit              = 1'b1;
                    o_result.token_kind = KIND_CLOSE;
                    if (is_gt) begin
                        n_mode             = MODE_IDLE;
                        o_result.token_end = 1'b1;
                    end else begin
                        o_result.has_char = 1'b1;
                        o_result.char_out = b;
                    end
                end
                MODE_SKIP: begin
                    // drop attribute bytes up to the closing bracket
                    if (is_gt) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    if (is_lt) begin
                        n_mode = MODE_LT;
                    end else begin
                        n_mode              = MODE_TEXT;
                        o_emit              = 1'b1;
                        o_result.token_kind = KIND_TEXT;
                        o_result.has_char   = 1'b1;
                        o_result.char_out   = b;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_step) begin
            r_mode <= n_mode;
        end
    end

endmodule : xtt_scan
`default_nettype wire

[rtl/xtt_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xtt_out_stage
// Result register: holds one token result until the consumer takes it.
// ----------------------------------------------------------------------------
module xtt_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire xtt_pkg::t_result i_result,
    input  wire logic          i_out_ready,
    output logic               o_slot_free,
    output logic               o_out_valid,
    output xtt_pkg::t_result   o_result
);
    import xtt_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_slot_free = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule : xtt_out_stage
`default_nettype wire

[rtl/xtt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xtt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module xtt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_token_kind,
    input wire logic       o_has_char,
    input wire logic [7:0] o_char_out,
    input wire logic       o_token_end,
    input wire logic       o_error_flag
);
    import xtt_pkg::*;

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_token_kind) && $stable(o_has_char) &&
            $stable(o_char_out) && $stable(o_token_end) && $stable(o_error_flag))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_char_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_char |-> !o_token_end && (o_token_kind != KIND_DONE))
        else $error("character result carries end mark or finish");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == KIND_DONE) |->
            !o_has_char && !o_token_end && (o_char_out == 8'h00))
        else $error("finish result carries token data");

    a_error_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_flag |-> (o_token_kind == KIND_DONE))
        else $error("error flag outside finish result");

endmodule : xtt_checker

bind xml_tag_text_tokenizer xtt_checker u_xtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_token_kind (o_token_kind),
    .o_has_char   (o_has_char),
    .o_char_out   (o_char_out),
    .o_token_end  (o_token_end),
    .o_error_flag (o_error_flag)
);
`default_nettype wire
